// File: rtl/core/car_pkg.sv
// Shared types, constants and default parameters for the centroid anchor reorder block.
`timescale 1ns / 1ps
`default_nettype none

package car_pkg;

  localparam int DEF_MAX_POINTS = 1024;
  localparam int DEF_MAX_DIM    = 128;

  localparam int PC_W   = 11;
  localparam int VD_W   = 8;
  localparam int CIDX_W = 2;
  localparam int CDAT_W = 11;
  localparam int ELEM_W = 8;
  localparam int POS_W  = 10;
  localparam int ID_W   = 10;
  localparam int DIST_W = 23;
  localparam int DSTO_W = 24;
  localparam int STAT_W = 2;

  localparam logic [CIDX_W-1:0] CFG_POINT_COUNT    = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_VECTOR_DIM     = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_ELEMENT_SIGNED = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_READY = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_POS   = 2'd2;

  localparam logic OPER_LOAD = 1'b0;
  localparam logic OPER_READ = 1'b1;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CFG,
    OP_LOAD,
    OP_RD_START,
    OP_RD_DIST,
    OP_RD_OUT,
    OP_SUM_INIT,
    OP_SUM_RD,
    OP_SUM_ACC,
    OP_SUM_WR,
    OP_SC_INIT,
    OP_SC_RD,
    OP_SC_MUL,
    OP_SC_SQ,
    OP_SC_ACC,
    OP_SC_CMP,
    OP_DI_INIT,
    OP_DI_RDA,
    OP_DI_RDP,
    OP_DI_SQ,
    OP_DI_ACC,
    OP_DI_WR,
    OP_RK_INIT,
    OP_RK_RDI,
    OP_RK_KEY,
    OP_RK_SCAN,
    OP_RK_WR
  } op_t;

  typedef struct packed {
    op_t  op;
    logic phase_done;
  } cmd_t;

  typedef struct packed {
    logic cfg_hit;
    logic load_last;
    logic i_last;
    logic j_last;
    logic scan_done;
  } stat_t;

endpackage

`default_nettype wire

// File: rtl/core/car_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module car_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/car_ctrl.sv
// Controller state machine: sequences load, read and the compute passes.
`timescale 1ns / 1ps
`default_nettype none

module car_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          operation,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire car_pkg::stat_t stat,
  output car_pkg::cmd_t      cmd
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_RD_DIST,
    S_RD_OUT,
    S_SUM_INIT,
    S_SUM_RD,
    S_SUM_ACC,
    S_SUM_WR,
    S_SC_INIT,
    S_SC_RD,
    S_SC_MUL,
    S_SC_SQ,
    S_SC_ACC,
    S_SC_CMP,
    S_DI_INIT,
    S_DI_RDA,
    S_DI_RDP,
    S_DI_SQ,
    S_DI_ACC,
    S_DI_WR,
    S_RK_INIT,
    S_RK_RDI,
    S_RK_KEY,
    S_RK_SCAN
  } state_t;

  state_t state, state_next;
  logic   phase_done, phase_done_next;
  logic   out_valid_next;
  car_pkg::op_t op;

  assign cfg_ready = (state == S_IDLE);
  assign in_ready  = (state == S_IDLE) && !cfg_valid;
  assign cmd.op = op;
  assign cmd.phase_done = phase_done;

  always_comb begin
    state_next      = state;
    phase_done_next = phase_done;
    out_valid_next  = out_valid && !out_ready;
    op              = car_pkg::OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (cfg_valid) begin
          op = car_pkg::OP_CFG;
          if (stat.cfg_hit) phase_done_next = 1'b0;
        end else if (in_valid) begin
          if (operation == car_pkg::OPER_LOAD) begin
            op = car_pkg::OP_LOAD;
            phase_done_next = 1'b0;
            if (stat.load_last) state_next = S_SUM_INIT;
          end else begin
            op = car_pkg::OP_RD_START;
            state_next = S_RD_DIST;
          end
        end
      end
      S_RD_DIST: begin
        op = car_pkg::OP_RD_DIST;
        state_next = S_RD_OUT;
      end
      S_RD_OUT: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          op = car_pkg::OP_RD_OUT;
          out_valid_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SUM_INIT: begin
        op = car_pkg::OP_SUM_INIT;
        state_next = S_SUM_RD;
      end
      S_SUM_RD: begin
        op = car_pkg::OP_SUM_RD;
        state_next = S_SUM_ACC;
      end
      S_SUM_ACC: begin
        op = car_pkg::OP_SUM_ACC;
        state_next = stat.i_last ? S_SUM_WR : S_SUM_RD;
      end
      S_SUM_WR: begin
        op = car_pkg::OP_SUM_WR;
        state_next = stat.j_last ? S_SC_INIT : S_SUM_RD;
      end
      S_SC_INIT: begin
        op = car_pkg::OP_SC_INIT;
        state_next = S_SC_RD;
      end
      S_SC_RD: begin
        op = car_pkg::OP_SC_RD;
        state_next = S_SC_MUL;
      end
      S_SC_MUL: begin
        op = car_pkg::OP_SC_MUL;
        state_next = S_SC_SQ;
      end
      S_SC_SQ: begin
        op = car_pkg::OP_SC_SQ;
        state_next = S_SC_ACC;
      end
      S_SC_ACC: begin
        op = car_pkg::OP_SC_ACC;
        state_next = stat.j_last ? S_SC_CMP : S_SC_RD;
      end
      S_SC_CMP: begin
        op = car_pkg::OP_SC_CMP;
        state_next = stat.i_last ? S_DI_INIT : S_SC_RD;
      end
      S_DI_INIT: begin
        op = car_pkg::OP_DI_INIT;
        state_next = S_DI_RDA;
      end
      S_DI_RDA: begin
        op = car_pkg::OP_DI_RDA;
        state_next = S_DI_RDP;
      end
      S_DI_RDP: begin
        op = car_pkg::OP_DI_RDP;
        state_next = S_DI_SQ;
      end
      S_DI_SQ: begin
        op = car_pkg::OP_DI_SQ;
        state_next = S_DI_ACC;
      end
      S_DI_ACC: begin
        op = car_pkg::OP_DI_ACC;
        state_next = stat.j_last ? S_DI_WR : S_DI_RDA;
      end
      S_DI_WR: begin
        op = car_pkg::OP_DI_WR;
        state_next = stat.i_last ? S_RK_INIT : S_DI_RDA;
      end
      S_RK_INIT: begin
        op = car_pkg::OP_RK_INIT;
        state_next = S_RK_RDI;
      end
      S_RK_RDI: begin
        op = car_pkg::OP_RK_RDI;
        state_next = S_RK_KEY;
      end
      S_RK_KEY: begin
        op = car_pkg::OP_RK_KEY;
        state_next = S_RK_SCAN;
      end
      S_RK_SCAN: begin
        if (stat.scan_done) begin
          op = car_pkg::OP_RK_WR;
          if (stat.i_last) begin
            phase_done_next = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = S_RK_RDI;
          end
        end else begin
          op = car_pkg::OP_RK_SCAN;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      phase_done <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      phase_done <= phase_done_next;
      out_valid  <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/car_dp.sv
// Datapath: configuration, memories, sum/score/distance arithmetic and rank counting.
`timescale 1ns / 1ps
`default_nettype none

module car_dp #(
  parameter int MAX_POINTS = car_pkg::DEF_MAX_POINTS,
  parameter int MAX_DIM    = car_pkg::DEF_MAX_DIM
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire car_pkg::cmd_t                 cmd,
  output car_pkg::stat_t                     stat,
  input  wire logic [car_pkg::CIDX_W-1:0]    cfg_index,
  input  wire logic [car_pkg::CDAT_W-1:0]    cfg_data,
  input  wire logic [car_pkg::ELEM_W-1:0]    element_value,
  input  wire logic [car_pkg::POS_W-1:0]     position,
  output logic      [car_pkg::ID_W-1:0]      old_id,
  output logic      [car_pkg::DIST_W-1:0]    distance,
  output logic                               is_anchor,
  output logic      [car_pkg::STAT_W-1:0]    status
);

  localparam int PW    = $clog2(MAX_POINTS);
  localparam int DW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int NW    = $clog2(MAX_POINTS + 1);
  localparam int DDW   = $clog2(MAX_DIM + 1);
  localparam int DEPTH = MAX_POINTS * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int LCW   = $clog2(DEPTH + 1);
  localparam int SW    = 9 + PW;
  localparam int SQW   = 2 * SW + 2;
  localparam int SCW   = SQW + DW;
  localparam int DSW   = car_pkg::DSTO_W;

  function automatic logic signed [8:0] to_elem(input logic [7:0] b, input logic sgn);
    to_elem = $signed({sgn & b[7], b});
  endfunction

  logic [car_pkg::PC_W-1:0] point_count;
  logic [car_pkg::VD_W-1:0] vector_dim;
  logic                     element_signed;
  logic [LCW-1:0]           load_count;

  logic [NW-1:0]  n_eff;
  logic [DDW-1:0] d_eff;
  logic [LCW-1:0] total;
  logic [LCW-1:0] ld_index;

  logic [PW-1:0]  ci, anchor, rank, sj, jd;
  logic [DW-1:0]  cj;
  logic [AW-1:0]  addr, base_i, base_a;
  logic signed [SW-1:0] acc_sum, prod, sum_q;
  logic [SQW-1:0] sq;
  logic [SCW-1:0] score, best;
  logic signed [8:0] anc_x;
  logic [16:0]    dsq;
  logic [DSW-1:0] dacc, key;
  logic           pend, issued_all;
  logic [car_pkg::STAT_W-1:0] rd_status;
  logic           rd_pos0;

  // memory ports
  logic            st_we, st_re;
  logic [AW-1:0]   st_waddr, st_raddr;
  logic [7:0]      st_rdata;
  logic            su_we, su_re;
  logic [DW-1:0]   su_waddr, su_raddr;
  logic [SW-1:0]   su_rdata;
  logic            di_we, di_re;
  logic [PW-1:0]   di_waddr, di_raddr;
  logic [DSW-1:0]  di_rdata;
  logic            or_we, or_re;
  logic [PW-1:0]   or_waddr, or_raddr, or_rdata;

  logic [31:0] pc32, vd32;
  logic [PW+car_pkg::POS_W-1:0] pos_ext;
  logic [PW+car_pkg::ID_W-1:0]  id_ext;
  logic signed [8:0]  st_elem;
  logic signed [NW+9:0] prod_full;
  logic signed [SW:0] diff;
  logic signed [SQW-1:0] sq_full;
  logic signed [9:0]  ddiff;
  logic signed [19:0] dsq_full;
  logic rank_hit;

  always_comb begin
    pc32 = 32'(point_count);
    vd32 = 32'(vector_dim);
    if (pc32 == 32'd0) n_eff = NW'(1);
    else if (pc32 > 32'(MAX_POINTS)) n_eff = NW'(MAX_POINTS);
    else n_eff = NW'(pc32);
    if (vd32 == 32'd0) d_eff = DDW'(1);
    else if (vd32 > 32'(MAX_DIM)) d_eff = DDW'(MAX_DIM);
    else d_eff = DDW'(vd32);
    total = LCW'(32'(n_eff) * 32'(d_eff));
    ld_index = (cmd.phase_done || load_count >= total) ? '0 : load_count;
    pos_ext = (PW + car_pkg::POS_W)'(position);
    id_ext  = (PW + car_pkg::ID_W)'(or_rdata);
    st_elem = to_elem(st_rdata, element_signed);
    prod_full = $signed({1'b0, n_eff}) * st_elem;
    diff = $signed({sum_q[SW-1], sum_q}) - $signed({prod[SW-1], prod});
    sq_full = diff * diff;
    ddiff = $signed({st_elem[8], st_elem}) - $signed({anc_x[8], anc_x});
    dsq_full = ddiff * ddiff;
    rank_hit = pend && (jd != anchor) && (jd != ci) &&
               ((di_rdata < key) || ((di_rdata == key) && (jd < ci)));
  end

  always_comb begin
    stat.cfg_hit   = (cfg_index == car_pkg::CFG_POINT_COUNT) ||
                     (cfg_index == car_pkg::CFG_VECTOR_DIM) ||
                     (cfg_index == car_pkg::CFG_ELEMENT_SIGNED);
    stat.load_last = (ld_index + LCW'(1)) == total;
    stat.i_last    = (NW'(ci) + NW'(1)) == n_eff;
    stat.j_last    = (DDW'(cj) + DDW'(1)) == d_eff;
    stat.scan_done = issued_all && !pend;
  end

  always_comb begin
    st_we = 1'b0; st_waddr = ld_index[AW-1:0];
    st_re = 1'b0; st_raddr = addr;
    su_we = 1'b0; su_waddr = cj;
    su_re = 1'b0; su_raddr = cj;
    di_we = 1'b0; di_waddr = ci;
    di_re = 1'b0; di_raddr = ci;
    or_we = 1'b0; or_waddr = (ci == anchor) ? '0 : rank;
    or_re = 1'b0; or_raddr = pos_ext[PW-1:0];
    case (cmd.op)
      car_pkg::OP_LOAD:     st_we = 1'b1;
      car_pkg::OP_RD_START: or_re = 1'b1;
      car_pkg::OP_RD_DIST: begin
        di_re = 1'b1;
        di_raddr = or_rdata;
      end
      car_pkg::OP_SUM_RD:   st_re = 1'b1;
      car_pkg::OP_SUM_WR:   su_we = 1'b1;
      car_pkg::OP_SC_RD: begin
        st_re = 1'b1;
        su_re = 1'b1;
      end
      car_pkg::OP_DI_RDA: begin
        st_re = 1'b1;
        st_raddr = base_a + AW'(cj);
      end
      car_pkg::OP_DI_RDP: begin
        st_re = 1'b1;
        st_raddr = base_i + AW'(cj);
      end
      car_pkg::OP_DI_WR:    di_we = 1'b1;
      car_pkg::OP_RK_RDI:   di_re = 1'b1;
      car_pkg::OP_RK_SCAN: begin
        di_re = !issued_all;
        di_raddr = sj;
      end
      car_pkg::OP_RK_WR:    or_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count    <= car_pkg::PC_W'(1);
      vector_dim     <= car_pkg::VD_W'(1);
      element_signed <= 1'b1;
      load_count     <= '0;
    end else begin
      case (cmd.op)
        car_pkg::OP_CFG: begin
          if (cfg_index == car_pkg::CFG_POINT_COUNT) point_count <= cfg_data;
          if (cfg_index == car_pkg::CFG_VECTOR_DIM) vector_dim <= cfg_data[car_pkg::VD_W-1:0];
          if (cfg_index == car_pkg::CFG_ELEMENT_SIGNED) element_signed <= cfg_data[0];
          if (stat.cfg_hit) load_count <= '0;
        end
        car_pkg::OP_LOAD: load_count <= ld_index + LCW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      car_pkg::OP_RD_START: begin
        rd_pos0 <= (position == '0);
        if (!cmd.phase_done) rd_status <= car_pkg::ST_NOT_READY;
        else if (32'(position) >= 32'(n_eff)) rd_status <= car_pkg::ST_BAD_POS;
        else rd_status <= car_pkg::ST_OK;
      end
      car_pkg::OP_RD_OUT: begin
        status <= rd_status;
        if (rd_status == car_pkg::ST_OK) begin
          old_id    <= id_ext[car_pkg::ID_W-1:0];
          distance  <= di_rdata[car_pkg::DIST_W-1:0];
          is_anchor <= rd_pos0;
        end else begin
          old_id    <= '0;
          distance  <= '0;
          is_anchor <= 1'b0;
        end
      end
      car_pkg::OP_SUM_INIT: begin
        ci <= '0; cj <= '0; addr <= '0; acc_sum <= '0;
      end
      car_pkg::OP_SUM_ACC: begin
        acc_sum <= acc_sum + SW'(st_elem);
        if (!stat.i_last) begin
          ci <= ci + PW'(1);
          addr <= addr + AW'(d_eff);
        end
      end
      car_pkg::OP_SUM_WR: begin
        acc_sum <= '0;
        ci <= '0;
        // next column starts at its own offset in the first vector
        cj <= cj + DW'(1);
        addr <= AW'(cj) + AW'(1);
      end
      car_pkg::OP_SC_INIT: begin
        ci <= '0; cj <= '0; addr <= '0; base_i <= '0; base_a <= '0;
        score <= '0; best <= '1; anchor <= '0;
      end
      car_pkg::OP_SC_MUL: begin
        prod  <= $signed(prod_full[SW-1:0]);
        sum_q <= $signed(su_rdata);
      end
      car_pkg::OP_SC_SQ: sq <= sq_full[SQW-1:0];
      car_pkg::OP_SC_ACC: begin
        score <= score + SCW'(sq);
        addr <= addr + AW'(1);
        if (!stat.j_last) cj <= cj + DW'(1);
      end
      car_pkg::OP_SC_CMP: begin
        // strict compare keeps the lower index on ties
        if (score < best) begin
          best <= score;
          anchor <= ci;
          base_a <= base_i;
        end
        score <= '0;
        cj <= '0;
        base_i <= addr;
        ci <= ci + PW'(1);
      end
      car_pkg::OP_DI_INIT: begin
        ci <= '0; cj <= '0; base_i <= '0; dacc <= '0;
      end
      car_pkg::OP_DI_RDP: anc_x <= st_elem;
      car_pkg::OP_DI_SQ:  dsq <= dsq_full[16:0];
      car_pkg::OP_DI_ACC: begin
        dacc <= dacc + DSW'(dsq);
        if (!stat.j_last) cj <= cj + DW'(1);
      end
      car_pkg::OP_DI_WR: begin
        dacc <= '0;
        cj <= '0;
        base_i <= base_i + AW'(d_eff);
        ci <= ci + PW'(1);
      end
      car_pkg::OP_RK_INIT: ci <= '0;
      car_pkg::OP_RK_KEY: begin
        key <= di_rdata;
        rank <= PW'(1);
        sj <= '0;
        pend <= 1'b0;
        issued_all <= 1'b0;
      end
      car_pkg::OP_RK_SCAN: begin
        if (!issued_all) begin
          jd <= sj;
          pend <= 1'b1;
          if ((NW'(sj) + NW'(1)) == n_eff) issued_all <= 1'b1;
          else sj <= sj + PW'(1);
        end else begin
          pend <= 1'b0;
        end
        if (rank_hit) rank <= rank + PW'(1);
      end
      car_pkg::OP_RK_WR: ci <= ci + PW'(1);
      default: ;
    endcase
  end

  car_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(element_value),
    .re(st_re), .raddr(st_raddr), .rdata(st_rdata)
  );

  car_ram #(.WIDTH(SW), .DEPTH(MAX_DIM)) u_sums (
    .clk(clk), .we(su_we), .waddr(su_waddr), .wdata(acc_sum),
    .re(su_re), .raddr(su_raddr), .rdata(su_rdata)
  );

  car_ram #(.WIDTH(DSW), .DEPTH(MAX_POINTS)) u_dist (
    .clk(clk), .we(di_we), .waddr(di_waddr), .wdata(dacc),
    .re(di_re), .raddr(di_raddr), .rdata(di_rdata)
  );

  car_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_order (
    .clk(clk), .we(or_we), .waddr(or_waddr), .wdata(ci),
    .re(or_re), .raddr(or_raddr), .rdata(or_rdata)
  );

endmodule

`default_nettype wire

// File: rtl/core/centroid_anchor_reorder.sv
// Top level of the centroid anchor reorder block: controller plus datapath.
//
// Channel  | Signals                                    | Dir
// input    | in_valid/in_ready, operation, element_value, position | in
// result   | out_valid/out_ready, old_id, distance, is_anchor, status | out
// config   | cfg_valid/cfg_ready, cfg_index, cfg_data    | in
//
// A read looks up the order memory, then the distance memory, then fills
// the output register, where it waits while the output is stalled.
// The last load of a dataset starts the compute passes (sums, anchor score,
// distances, rank count); inputs stall until they finish. Synchronous reset
// restores control state and the default configuration only; no clearing
// pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module centroid_anchor_reorder #(
  parameter int MAX_POINTS = car_pkg::DEF_MAX_POINTS,
  parameter int MAX_DIM    = car_pkg::DEF_MAX_DIM
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          operation,
  input  wire logic [car_pkg::ELEM_W-1:0]    element_value,
  input  wire logic [car_pkg::POS_W-1:0]     position,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [car_pkg::ID_W-1:0]      old_id,
  output logic      [car_pkg::DIST_W-1:0]    distance,
  output logic                               is_anchor,
  output logic      [car_pkg::STAT_W-1:0]    status,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [car_pkg::CIDX_W-1:0]    cfg_index,
  input  wire logic [car_pkg::CDAT_W-1:0]    cfg_data
);

  car_pkg::cmd_t  cmd;
  car_pkg::stat_t stat;

  car_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .operation(operation),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .stat(stat), .cmd(cmd)
  );

  car_dp #(.MAX_POINTS(MAX_POINTS), .MAX_DIM(MAX_DIM)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .element_value(element_value), .position(position),
    .old_id(old_id), .distance(distance), .is_anchor(is_anchor), .status(status)
  );

endmodule

`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for the centroid anchor reorder block.
`timescale 1ns / 1ps

module testbench;
  import car_pkg::*;

  localparam logic [CIDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 6000000;
  localparam int READ_CAP = 64;

  typedef struct {
    logic [ID_W-1:0]   id;
    logic [DIST_W-1:0] dval;
    logic              anch;
    logic [STAT_W-1:0] st;
  } read_result_t;

  class reorder_board;
    int unsigned n_reg, d_reg, sgn_reg;
    byte unsigned elems[DEF_MAX_POINTS*DEF_MAX_DIM];
    int unsigned pt_dist[DEF_MAX_POINTS];
    int unsigned order[DEF_MAX_POINTS];
    int unsigned load_cnt;
    bit done;
    read_result_t expected_reads[$];
    int errors, loads, reads, datasets, results_seen;

    function new();
      n_reg = 1; d_reg = 1; sgn_reg = 1;
      load_cnt = 0; done = 0;
      errors = 0; loads = 0; reads = 0; datasets = 0; results_seen = 0;
    endfunction

    function int unsigned eff_n();
      if (n_reg < 1) return 1;
      if (n_reg > DEF_MAX_POINTS) return DEF_MAX_POINTS;
      return n_reg;
    endfunction

    function int unsigned eff_d();
      if (d_reg < 1) return 1;
      if (d_reg > DEF_MAX_DIM) return DEF_MAX_DIM;
      return d_reg;
    endfunction

    function int el(int unsigned idx);
      int v;
      v = elems[idx];
      if (sgn_reg != 0 && v >= 128) v -= 256;
      return v;
    endfunction

    // anchor by scaled centroid distance, then distances and a stable rank
    function void rank_points();
      int unsigned n, d, i, j, k, cnt, anch, dd;
      longint sums[DEF_MAX_DIM];
      longint df, sc, best;
      int e;
      n = eff_n();
      d = eff_d();
      for (j = 0; j < d; j++) sums[j] = 0;
      for (i = 0; i < n; i++)
        for (j = 0; j < d; j++) sums[j] += el(i*d + j);
      anch = 0;
      best = -1;
      for (i = 0; i < n; i++) begin
        sc = 0;
        for (j = 0; j < d; j++) begin
          df = sums[j] - longint'(n) * el(i*d + j);
          sc += df * df;
        end
        if (best < 0 || sc < best) begin
          best = sc;
          anch = i;
        end
      end
      for (i = 0; i < n; i++) begin
        dd = 0;
        if (i != anch)
          for (j = 0; j < d; j++) begin
            e = el(i*d + j) - el(anch*d + j);
            dd += e * e;
          end
        pt_dist[i] = dd & 24'hFFFFFF;
      end
      order[0] = anch;
      cnt = 1;
      for (i = 0; i < n; i++) begin
        if (i == anch) continue;
        k = cnt;
        while (k > 1 && pt_dist[order[k-1]] > pt_dist[i]) begin
          order[k] = order[k-1];
          k--;
        end
        order[k] = i;
        cnt++;
      end
      done = 1;
      datasets++;
    endfunction

    function void write_reg(logic [CIDX_W-1:0] idx, logic [CDAT_W-1:0] data);
      case (idx)
        CFG_POINT_COUNT:    n_reg = data;
        CFG_VECTOR_DIM:     d_reg = data[VD_W-1:0];
        CFG_ELEMENT_SIGNED: sgn_reg = data[0];
        default: return;
      endcase
      load_cnt = 0;
      done = 0;
    endfunction

    function void note_input(logic op, logic [ELEM_W-1:0] val, logic [POS_W-1:0] pos);
      int unsigned total;
      read_result_t r;
      if (op == OPER_LOAD) begin
        total = eff_n() * eff_d();
        if (done) begin
          done = 0;
          load_cnt = 0;
        end
        if (load_cnt >= total) load_cnt = 0;
        elems[load_cnt] = val;
        load_cnt++;
        loads++;
        if (load_cnt == total) rank_points();
      end else begin
        r.id = 0; r.dval = 0; r.anch = 0;
        if (!done) r.st = ST_NOT_READY;
        else if (pos >= eff_n()) r.st = ST_BAD_POS;
        else begin
          r.id = ID_W'(order[pos]);
          r.dval = pt_dist[order[pos]][DIST_W-1:0];
          r.anch = (pos == 0);
          r.st = ST_OK;
        end
        expected_reads.push_back(r);
        reads++;
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 20) $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task check(read_result_t got);
      read_result_t w;
      results_seen++;
      if (expected_reads.size() == 0) begin
        report($sformatf("result with nothing pending (id %0d status %0d)", got.id, got.st));
        return;
      end
      w = expected_reads.pop_front();
      if (got.st !== w.st) report($sformatf("status %0d, want %0d", got.st, w.st));
      if (got.id !== w.id) report($sformatf("old_id %0d, want %0d", got.id, w.id));
      if (got.dval !== w.dval) report($sformatf("distance %0d, want %0d", got.dval, w.dval));
      if (got.anch !== w.anch) report($sformatf("is_anchor %0b, want %0b", got.anch, w.anch));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic operation = OPER_LOAD;
  logic [ELEM_W-1:0] element_value = '0;
  logic [POS_W-1:0] position = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ID_W-1:0] old_id;
  logic [DIST_W-1:0] distance;
  logic is_anchor;
  logic [STAT_W-1:0] status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [CDAT_W-1:0] cfg_data = '0;

  reorder_board board = new();
  bit burst = 0;
  bit held = 0;
  int items_sent = 0;
  int stall_cycles = 0;

  always #5 clk = ~clk;

  centroid_anchor_reorder u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .element_value(element_value), .position(position),
    .out_valid(out_valid), .out_ready(out_ready),
    .old_id(old_id), .distance(distance), .is_anchor(is_anchor), .status(status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  function int pick_gap();
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    read_result_t got;
    if (!rst && out_valid && out_ready) begin
      got.id = old_id; got.dval = distance; got.anch = is_anchor; got.st = status;
      board.check(got);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) || rst)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off to back up the block
  initial begin
    int g;
    @(negedge rst);
    forever begin
      out_ready <= 1'b1;
      repeat (1 + $urandom_range(0, 8)) @(posedge clk);
      g = pick_gap();
      if (g > 0) begin
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      if (!held && board.results_seen > 150) begin
        out_ready <= 1'b0;
        repeat (600) @(posedge clk);
        held = 1;
      end
    end
  end

  task offer_item(logic op, logic [ELEM_W-1:0] val, logic [POS_W-1:0] pos);
    int g;
    in_valid <= 1'b1;
    operation <= op;
    element_value <= val;
    position <= pos;
    do @(posedge clk); while (!in_ready);
    board.note_input(op, val, pos);
    items_sent++;
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task drain();
    in_valid <= 1'b0;
    while (board.expected_reads.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task write_cfg(logic [CIDX_W-1:0] idx, logic [CDAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task set_dataset(int n, int d, int sgn);
    write_cfg(CFG_POINT_COUNT, CDAT_W'(n));
    write_cfg(CFG_VECTOR_DIM, CDAT_W'(d));
    write_cfg(CFG_ELEMENT_SIGNED, CDAT_W'(sgn));
  endtask

  function logic [POS_W-1:0] pick_pos();
    if ($urandom_range(0, 4) == 0) return POS_W'($urandom());
    return POS_W'($urandom_range(0, board.eff_n()));
  endfunction

  initial begin
    int phase_no, n, d, sgn, reps, total, stop_at, k, nrd;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // defaults: one point of one signed element
    offer_item(OPER_READ, 8'h00, 10'd0);
    offer_item(OPER_LOAD, 8'h80, 10'd0);
    offer_item(OPER_READ, 8'h00, 10'd0);
    offer_item(OPER_READ, 8'h00, 10'd1);
    offer_item(OPER_READ, 8'hFF, 10'd1023);
    offer_item(OPER_LOAD, 8'h7F, 10'h3FF);
    offer_item(OPER_READ, 8'h00, 10'd0);
    drain();

    set_dataset(3, 2, 0);
    offer_item(OPER_LOAD, 8'h00, 10'd0);
    offer_item(OPER_LOAD, 8'hFF, 10'd0);
    offer_item(OPER_LOAD, 8'hFF, 10'd0);
    offer_item(OPER_READ, 8'h00, 10'd0);
    offer_item(OPER_LOAD, 8'h00, 10'd0);
    offer_item(OPER_LOAD, 8'h80, 10'd0);
    offer_item(OPER_LOAD, 8'h7F, 10'd0);
    for (k = 0; k < 4; k++) offer_item(OPER_READ, 8'h00, POS_W'(k));
    // partial dataset, then a write to the unused index, which does not discard it
    offer_item(OPER_LOAD, 8'h11, 10'd0);
    offer_item(OPER_LOAD, 8'h22, 10'd0);
    drain();
    write_cfg(CFG_UNUSED, 11'h7FF);
    offer_item(OPER_READ, 8'h00, 10'd0);
    drain();
    set_dataset(0, 256, 1);
    offer_item(OPER_LOAD, 8'hC3, 10'd0);
    offer_item(OPER_READ, 8'h00, 10'd0);
    offer_item(OPER_READ, 8'h00, 10'd1);
    drain();

    phase_no = 0;
    while (items_sent < 2000) begin
      burst = ($urandom_range(0, 3) == 0);
      sgn = $urandom_range(0, 1);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      d = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
      if (phase_no == 1) begin n = 2; d = 255; end
      if (phase_no == 3) begin n = 2047; d = 1; end
      if (phase_no == 5) begin n = 1024; d = 128; end
      if (phase_no == 5) n = 2;
      set_dataset(n, d, sgn);
      total = board.eff_n() * board.eff_d();
      // one pass only for the largest point count to keep the item count in range
      reps = (phase_no == 3) ? 1 : $urandom_range(1, 3);
      for (int r = 0; r < reps; r++) begin
        stop_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, total) : total;
        for (k = 0; k < stop_at; k++) begin
          if ($urandom_range(0, 19) == 0)
            offer_item(OPER_READ, ELEM_W'($urandom()), pick_pos());
          offer_item(OPER_LOAD, ELEM_W'($urandom()), POS_W'($urandom()));
        end
        nrd = (board.eff_n() > READ_CAP) ? READ_CAP : board.eff_n();
        nrd = nrd + $urandom_range(1, 4);
        for (k = 0; k < nrd; k++)
          offer_item(OPER_READ, ELEM_W'($urandom()), pick_pos());
        if (stop_at != total) break;
      end
      offer_item(OPER_READ, ELEM_W'($urandom()), pick_pos());
      drain();
      phase_no++;
    end

    drain();
    repeat (50) @(posedge clk);
    $display("covered %0d loads, %0d reads, %0d ranked datasets over %0d config phases",
             board.loads, board.reads, board.datasets, phase_no);
    $display("%0d results checked, %0d mismatches", board.results_seen, board.errors);
    if (board.errors == 0 && board.expected_reads.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
